FILE: hw/rtl/pcss_pkg.sv
// ============================================================================
// pcss_pkg: shared types and constants of the crop/scale sampler
// Field widths, register indexes, input mode and status codes, the clamped
// geometry record handed from the register block, and the per-stage
// sideband record of the request pipeline.
// ============================================================================
package pcss_pkg;

  // Default sizing
  localparam int DEF_MAX_DIM     = 2048;
  localparam int DEF_STORE_BYTES = 1048576;

  // Field widths
  localparam int CFG_W   = 12;  // widest configuration register
  localparam int COORD_W = 11;  // coordinates and crop origin
  localparam int RAW_W   = 20;  // byte address before wrapping
  localparam int DATA_W  = 8;   // packed byte
  localparam int PIX_W   = 2;   // gray level
  localparam int BPR_W   = 10;  // bytes per row, up to 512
  localparam int IDX_W   = 3;   // register index
  localparam int NUM_W   = COORD_W + CFG_W;  // coordinate times crop size

  // Register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CROP_LEFT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROP_TOP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROP_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROP_HEIGHT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_VIEW_WIDTH   = 3'd6;
  localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT  = 3'd7;

  // Input modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Pixel slot selects, first pixel in the top bits
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  // Clamped geometry, ready for use by the request pipeline
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [CFG_W-1:0]   cw;
    logic [CFG_W-1:0]   ch;
    logic [CFG_W-1:0]   vw;
    logic [CFG_W-1:0]   vh;
    logic [BPR_W-1:0]   bpr;
  } geom_t;

  // Sideband carried along the request pipeline
  typedef struct packed {
    logic               mode;
    logic [DATA_W-1:0]  byte_data;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               err;
    logic [1:0]         sx_lo;
    logic [RAW_W-1:0]   raw;
  } stage_t;

endpackage

FILE: hw/rtl/pcss_ram.sv
// ============================================================================
// pcss_ram: generic single-port synchronous RAM
// One access per cycle, write or read; read data registered and held while
// the port is idle.
// ============================================================================
module pcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/pcss_cfg.sv
// ============================================================================
// pcss_cfg: configuration registers and geometry clamping
// Holds the eight registers and registers the clamped image, crop and
// viewport geometry derived from them.
// ============================================================================
module pcss_cfg #(
  parameter int MAX_DIM = pcss_pkg::DEF_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pcss_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pcss_pkg::CFG_W-1:0]  cfg_data,
  output pcss_pkg::geom_t             geom
);

  localparam logic [pcss_pkg::CFG_W-1:0] DIM_MAX = pcss_pkg::CFG_W'(MAX_DIM);
  localparam logic [pcss_pkg::CFG_W-1:0] ONE     = pcss_pkg::CFG_W'(1);

  logic [pcss_pkg::CFG_W-1:0]   image_width, image_height;
  logic [pcss_pkg::COORD_W-1:0] crop_left, crop_top;
  logic [pcss_pkg::CFG_W-1:0]   crop_width, crop_height;
  logic [pcss_pkg::CFG_W-1:0]   view_width, view_height;

  logic [pcss_pkg::CFG_W-1:0]   w, h, left_c, top_c, room_w, room_h;
  logic [pcss_pkg::CFG_W:0]     w_pad;
  pcss_pkg::geom_t              geom_next;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ONE;
      image_height <= ONE;
      crop_left    <= '0;
      crop_top     <= '0;
      crop_width   <= ONE;
      crop_height  <= ONE;
      view_width   <= ONE;
      view_height  <= ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        pcss_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pcss_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        pcss_pkg::REG_CROP_LEFT:    crop_left    <= cfg_data[pcss_pkg::COORD_W-1:0];
        pcss_pkg::REG_CROP_TOP:     crop_top     <= cfg_data[pcss_pkg::COORD_W-1:0];
        pcss_pkg::REG_CROP_WIDTH:   crop_width   <= cfg_data;
        pcss_pkg::REG_CROP_HEIGHT:  crop_height  <= cfg_data;
        pcss_pkg::REG_VIEW_WIDTH:   view_width   <= cfg_data;
        pcss_pkg::REG_VIEW_HEIGHT:  view_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp image size, then crop origin, then crop size; cap the viewport size
  always_comb begin
    w = (image_width == '0) ? ONE : ((image_width > DIM_MAX) ? DIM_MAX : image_width);
    h = (image_height == '0) ? ONE : ((image_height > DIM_MAX) ? DIM_MAX : image_height);

    left_c = (pcss_pkg::CFG_W'(crop_left) > w - ONE) ? w - ONE : pcss_pkg::CFG_W'(crop_left);
    top_c  = (pcss_pkg::CFG_W'(crop_top) > h - ONE) ? h - ONE : pcss_pkg::CFG_W'(crop_top);
    room_w = w - left_c;
    room_h = h - top_c;

    geom_next.left = left_c[pcss_pkg::COORD_W-1:0];
    geom_next.top  = top_c[pcss_pkg::COORD_W-1:0];
    geom_next.cw   = (crop_width == '0) ? ONE :
                     ((crop_width > room_w) ? room_w : crop_width);
    geom_next.ch   = (crop_height == '0) ? ONE :
                     ((crop_height > room_h) ? room_h : crop_height);
    geom_next.vw   = (view_width > DIM_MAX) ? DIM_MAX : view_width;
    geom_next.vh   = (view_height > DIM_MAX) ? DIM_MAX : view_height;

    // bytes per row: ceil(w / 4)
    w_pad          = (pcss_pkg::CFG_W + 1)'(w) + (pcss_pkg::CFG_W + 1)'(3);
    geom_next.bpr  = pcss_pkg::BPR_W'(w_pad >> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.left <= '0;
      geom.top  <= '0;
      geom.cw   <= ONE;
      geom.ch   <= ONE;
      geom.vw   <= ONE;
      geom.vh   <= ONE;
      geom.bpr  <= pcss_pkg::BPR_W'(1);
    end else begin
      geom <= geom_next;
    end
  end

endmodule

FILE: hw/rtl/pcss_scale_div.sv
// ============================================================================
// pcss_scale_div: pipelined nearest-neighbor scale for one axis
// Registers d*size, then takes floor(d*size/view) one quotient bit per
// stage by restoring division. Valid only for d < view, where the quotient
// stays below size and needs no clamp.
// ============================================================================
module pcss_scale_div #(
  parameter int QW = 11
) (
  input  logic                         clk,
  input  logic [QW:0]                  en,
  input  logic [pcss_pkg::COORD_W-1:0] d,
  input  logic [pcss_pkg::CFG_W-1:0]   size,
  input  logic [pcss_pkg::CFG_W-1:0]   view,
  output logic [QW-1:0]                q
);

  logic [pcss_pkg::NUM_W-1:0] prod;
  logic [pcss_pkg::CFG_W-1:0] rem_r [QW];
  logic [QW-1:0]              low_r [QW];
  logic [QW-1:0]              q_r   [QW];

  // Numerator
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= pcss_pkg::NUM_W'(d) * pcss_pkg::NUM_W'(size);
    end
  end

  // One quotient bit per stage; top bits of the product seed the remainder
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [pcss_pkg::CFG_W-1:0] rem_in;
    logic [QW-1:0]              low_in, q_in;
    logic [pcss_pkg::CFG_W:0]   t;
    logic                       ge;

    if (k == 0) begin : g_first
      assign rem_in = pcss_pkg::CFG_W'(prod >> QW);
      assign low_in = prod[QW-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign t  = {rem_in, low_in[QW-1]};
    assign ge = (t >= {1'b0, view});

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        rem_r[k] <= ge ? pcss_pkg::CFG_W'(t - {1'b0, view}) : pcss_pkg::CFG_W'(t);
        low_r[k] <= low_in << 1;
        q_r[k]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

FILE: hw/rtl/packed_2bpp_crop_scale_sampler_core.sv
// ============================================================================
// packed_2bpp_crop_scale_sampler_core: packed 2bpp image store and sampler
// Mode 0 items write a packed byte into the image RAM. Mode 1 items map a
// viewport coordinate through the clamped crop window by nearest-neighbor
// scaling, read the byte holding the source pixel and return its level.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | mode, byte_address, byte_data, dest_x/y
//  out     | out_valid / out_stall | pixel, out_x, out_y, status
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  One item per cycle unless in_stall is high. The depth of the pixel path
//  is set by the bit-per-stage scale divider and the wrap of the byte
//  address.
//  Writes and reads reach the single RAM port in item order, one per cycle,
//  so a read always sees every earlier write.
//  Stalls collapse bubbles: in_stall rises only when every stage is full
//  and out_stall is high. Reset clears control only; the RAM is not cleared.
//  A geometry write takes effect for items accepted from the next cycle on.
//
module packed_2bpp_crop_scale_sampler_core #(
  parameter int MAX_DIM     = pcss_pkg::DEF_MAX_DIM,
  parameter int STORE_BYTES = pcss_pkg::DEF_STORE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [pcss_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pcss_pkg::CFG_W-1:0]   cfg_data,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [pcss_pkg::RAW_W-1:0]   byte_address,
  input  logic [pcss_pkg::DATA_W-1:0]  byte_data,
  input  logic [pcss_pkg::COORD_W-1:0] dest_x,
  input  logic [pcss_pkg::COORD_W-1:0] dest_y,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pcss_pkg::PIX_W-1:0]   pixel,
  output logic [pcss_pkg::COORD_W-1:0] out_x,
  output logic [pcss_pkg::COORD_W-1:0] out_y,
  output logic                         status
);

  localparam int RAW_W = pcss_pkg::RAW_W;
  localparam int QW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(STORE_BYTES);

  // Stage map
  localparam int DIV_LAST = 1 + QW;          // scaled offsets registered
  localparam int S_SRC    = DIV_LAST + 1;    // source coordinate
  localparam int S_RAW    = S_SRC + 1;       // linear byte address
  localparam int S_PROD   = S_RAW + 1;       // reciprocal product
  localparam int S_QC     = S_PROD + 1;      // quotient times store size
  localparam int S_ADDR   = S_QC + 1;        // wrapped address, RAM access
  localparam int S_OUT    = S_ADDR + 1;      // result register
  localparam int NST      = S_OUT + 1;

  // Address wrap by reciprocal: floor(v/C) = (v*M) >> (RAW_W+SH), exact for
  // every RAW_W-bit v with M = ceil(2^(RAW_W+SH)/C) and 2^SH >= C.
  localparam int          MOD_SH    = $clog2(STORE_BYTES);
  localparam int          MUL_W     = RAW_W + 1;
  localparam int          PROD_W    = RAW_W + MUL_W;
  localparam logic [63:0] MOD_ONE   = 64'd1 << (RAW_W + MOD_SH);
  localparam logic [63:0] MOD_MUL64 = (MOD_ONE + 64'(STORE_BYTES) - 64'd1) / 64'(STORE_BYTES);
  localparam logic [MUL_W-1:0] MOD_MUL = MUL_W'(MOD_MUL64);

  pcss_pkg::geom_t geom;

  logic [NST-1:0]    valid, valid_in, ready;
  pcss_pkg::stage_t  sb    [S_OUT];
  pcss_pkg::stage_t  sb_in [S_OUT];

  logic [QW-1:0]                qx, qy;
  logic [pcss_pkg::COORD_W-1:0] sx, sy, sx_next, sy_next;
  logic [RAW_W-1:0]             raw_calc, quo, qc, diff;
  logic [PROD_W-1:0]            mod_prod;
  logic [AW-1:0]                addr;

  logic                         ram_en;
  logic [pcss_pkg::DATA_W-1:0]  ram_rdata;
  logic [1:0]                   out_slot;
  logic [pcss_pkg::PIX_W-1:0]   pix_sel;

  // Configuration and clamped geometry
  pcss_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // A stage may load when the output is not stalled or any stage from it to the output has room
  for (genvar i = 0; i < NST; i++) begin : g_ready
    assign ready[i] = !out_stall || !(&valid[NST-1:i]);
  end

  assign in_stall = !ready[0];

  // Valid shift with bubble collapse; write items end at the RAM
  always_comb begin
    valid_in[0] = in_valid;
    for (int i = 1; i < NST; i++) begin
      valid_in[i] = valid[i-1];
    end
    valid_in[S_OUT] = valid[S_ADDR] && (sb[S_ADDR].mode == pcss_pkg::MODE_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (ready[i]) valid[i] <= valid_in[i];
      end
    end
  end

  // Sideband line: request fields, range check, source pixel slot, address
  always_comb begin
    sb_in[0].mode      = mode;
    sb_in[0].byte_data = byte_data;
    sb_in[0].dest_x    = dest_x;
    sb_in[0].dest_y    = dest_y;
    sb_in[0].err       = 1'b0;
    sb_in[0].sx_lo     = '0;
    sb_in[0].raw       = byte_address;
    for (int i = 1; i < S_OUT; i++) begin
      sb_in[i] = sb[i-1];
    end
    sb_in[1].err = (pcss_pkg::CFG_W'(sb[0].dest_x) >= geom.vw) ||
                   (pcss_pkg::CFG_W'(sb[0].dest_y) >= geom.vh);
    sb_in[S_SRC].sx_lo = sx_next[1:0];
    if (sb[S_SRC].mode == pcss_pkg::MODE_PIXEL) begin
      sb_in[S_RAW].raw = raw_calc;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < S_OUT; i++) begin
      if (ready[i]) sb[i] <= sb_in[i];
    end
  end

  // Scaled offsets within the crop window
  pcss_scale_div #(
    .QW (QW)
  ) u_div_x (
    .clk  (clk),
    .en   (ready[DIV_LAST:1]),
    .d    (sb[0].dest_x),
    .size (geom.cw),
    .view (geom.vw),
    .q    (qx)
  );

  pcss_scale_div #(
    .QW (QW)
  ) u_div_y (
    .clk  (clk),
    .en   (ready[DIV_LAST:1]),
    .d    (sb[0].dest_y),
    .size (geom.ch),
    .view (geom.vh),
    .q    (qy)
  );

  // Source coordinate
  assign sx_next = pcss_pkg::COORD_W'(pcss_pkg::CFG_W'(geom.left) + pcss_pkg::CFG_W'(qx));
  assign sy_next = pcss_pkg::COORD_W'(pcss_pkg::CFG_W'(geom.top) + pcss_pkg::CFG_W'(qy));

  always_ff @(posedge clk) begin
    if (ready[S_SRC]) begin
      sx <= sx_next;
      sy <= sy_next;
    end
  end

  // Row base plus byte within the row; fits RAW_W bits for any clamped size
  assign raw_calc = RAW_W'((RAW_W + 1)'(sy) * (RAW_W + 1)'(geom.bpr)) +
                    RAW_W'(sx[pcss_pkg::COORD_W-1:2]);

  // Wrap to the store size
  assign quo  = RAW_W'(mod_prod >> (RAW_W + MOD_SH));
  assign diff = sb[S_QC].raw - qc;

  always_ff @(posedge clk) begin
    if (ready[S_PROD]) mod_prod <= PROD_W'(sb[S_RAW].raw) * PROD_W'(MOD_MUL);
    if (ready[S_QC])   qc       <= RAW_W'(PROD_W'(quo) * PROD_W'(STORE_BYTES));
    if (ready[S_ADDR]) addr     <= diff[AW-1:0];
  end

  // Image store: one access per item, in item order
  assign ram_en = valid[S_ADDR] && ready[S_OUT];

  pcss_ram #(
    .WIDTH (pcss_pkg::DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (sb[S_ADDR].mode == pcss_pkg::MODE_WRITE),
    .addr  (addr),
    .wdata (sb[S_ADDR].byte_data),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (ready[S_OUT]) begin
      out_x    <= sb[S_ADDR].dest_x;
      out_y    <= sb[S_ADDR].dest_y;
      status   <= sb[S_ADDR].err ? pcss_pkg::STATUS_RANGE : pcss_pkg::STATUS_OK;
      out_slot <= sb[S_ADDR].sx_lo;
    end
  end

  // Pick the pixel out of the held read data
  always_comb begin
    case (out_slot)
      pcss_pkg::SLOT_0: pix_sel = ram_rdata[7:6];
      pcss_pkg::SLOT_1: pix_sel = ram_rdata[5:4];
      pcss_pkg::SLOT_2: pix_sel = ram_rdata[3:2];
      pcss_pkg::SLOT_3: pix_sel = ram_rdata[1:0];
      default:          pix_sel = '0;
    endcase
  end

  assign pixel     = (status == pcss_pkg::STATUS_RANGE) ? '0 : pix_sel;
  assign out_valid = valid[S_OUT];

endmodule
